// ----- hw/rtl/mix_matrix_channel_reducer_defines.svh -----
// assertion macros for the mixing-matrix channel reducer checker
`ifndef MIX_MATRIX_CHANNEL_REDUCER_DEFINES_SVH
`define MIX_MATRIX_CHANNEL_REDUCER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define MMCR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MMCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/mmcr_pkg.sv -----
// shared types, constants and helpers of the mixing-matrix channel reducer
`timescale 1ns / 1ps

package mmcr_pkg;

    // field widths
    localparam int IDX_W      = 5;
    localparam int CLS_W      = 2;
    localparam int CNT_W      = 6;
    localparam int MASK_W     = 32;
    localparam int CFG_ADDR_W = 2;

    // stream payload layout
    localparam int S_TDATA_W    = 16;
    localparam int ROW_LSB      = 0;
    localparam int COL_LSB      = ROW_LSB + IDX_W;
    localparam int CLS_LSB      = COL_LSB + IDX_W;
    localparam int M_TDATA_W    = 112;
    localparam int ZERO_LSB     = 0;
    localparam int IN_SKIP_LSB  = ZERO_LSB + MASK_W;
    localparam int OUT_SKIP_LSB = IN_SKIP_LSB + MASK_W;
    localparam int OUT_CNT_LSB  = OUT_SKIP_LSB + MASK_W;
    localparam int IN_CNT_LSB   = OUT_CNT_LSB + CNT_W;
    localparam int M_USED_W     = IN_CNT_LSB + CNT_W;
    localparam int M_PAD_W      = M_TDATA_W - M_USED_W;

    // coefficient classes
    localparam logic [CLS_W-1:0] CLS_ZERO  = 2'd0;
    localparam logic [CLS_W-1:0] CLS_ONE   = 2'd1;
    localparam logic [CLS_W-1:0] CLS_OTHER = 2'd2;
    localparam logic [CLS_W-1:0] CLS_RSVD  = 2'd3;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_IN_CHANNELS  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_CHANNELS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_START_IN     = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_START_OUT    = 2'd3;

    localparam logic [CNT_W-1:0] CFG_RESET_VAL = 6'd2;

    typedef struct packed {
        logic [CNT_W-1:0] in_channels;
        logic [CNT_W-1:0] out_channels;
        logic [CNT_W-1:0] start_in_count;
        logic [CNT_W-1:0] start_out_count;
    } mmcr_cfg_t;

    typedef struct packed {
        logic [MASK_W-1:0] output_zero_mask;
        logic [MASK_W-1:0] input_skip_mask;
        logic [MASK_W-1:0] output_skip_mask;
        logic [CNT_W-1:0]  out_count;
        logic [CNT_W-1:0]  in_count;
    } mmcr_result_t;

    typedef struct packed {
        logic idle;
        logic done;
    } mmcr_status_t;

    // address width of the coefficient store
    function automatic int store_addr_w(input int max_ch);
        int depth;
        depth = max_ch * max_ch;
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // decrement that stops at zero
    function automatic logic [CNT_W-1:0] dec_sat(input logic [CNT_W-1:0] v);
        return (v == '0) ? v : v - CNT_W'(1);
    endfunction

endpackage

// ----- hw/rtl/mix_matrix_channel_reducer.sv -----
// Matrix entries load one per cycle while s_tready is high; a last entry starts the analysis
// and blocks s_tready. The channel counts nin and nout are limited to MAX_CH, at most 32.
// The analysis is set by the store read port: one matrix entry per cycle, then one
// channel per cycle in each mask pass. Reset (aresetn, synchronous, low) sets the
// registers to 2 and clears control state; the coefficient store is not cleared.
`timescale 1ns / 1ps

module mix_matrix_channel_reducer
    import mmcr_pkg::*;
#(
    parameter int MAX_CH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input entries
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // row[4:0], col[9:5], entry_class[11:10]
    input  logic                  s_tlast,
    // analysis results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // output_zero_mask[31:0], input_skip_mask[63:32],
                                             // output_skip_mask[95:64], out_count[101:96],
                                             // in_count[107:102]
    // register writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CNT_W-1:0]      cfg_wdata
);

    localparam int AW = store_addr_w(MAX_CH);

    mmcr_cfg_t    cfg_reg;
    mmcr_status_t status;
    mmcr_result_t result;

    logic                 s_accept;
    logic [IDX_W-1:0]     row, col;
    logic [CLS_W-1:0]     cls_raw, cls;
    logic                 in_range;
    logic [AW-1:0]        wr_addr;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [CLS_W-1:0]     rd_data;
    logic                 res_take;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.in_channels     <= CFG_RESET_VAL;
            cfg_reg.out_channels    <= CFG_RESET_VAL;
            cfg_reg.start_in_count  <= CFG_RESET_VAL;
            cfg_reg.start_out_count <= CFG_RESET_VAL;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_IN_CHANNELS:  cfg_reg.in_channels     <= cfg_wdata;
                REG_OUT_CHANNELS: cfg_reg.out_channels    <= cfg_wdata;
                REG_START_IN:     cfg_reg.start_in_count  <= cfg_wdata;
                REG_START_OUT:    cfg_reg.start_out_count <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // entry decode, reserved class counts as other
    assign s_accept = s_tvalid && s_tready;
    assign row      = s_tdata[ROW_LSB +: IDX_W];
    assign col      = s_tdata[COL_LSB +: IDX_W];
    assign cls_raw  = s_tdata[CLS_LSB +: CLS_W];
    assign cls      = (cls_raw == CLS_RSVD) ? CLS_OTHER : cls_raw;
    assign in_range = (32'(row) < MAX_CH) && (32'(col) < MAX_CH);
    assign wr_addr  = AW'(AW'(row) * AW'(MAX_CH)) + AW'(col);

    mmcr_store #(
        .MAX_CH (MAX_CH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (s_accept && in_range),
        .wr_addr (wr_addr),
        .wr_data (cls),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mmcr_analyzer #(
        .MAX_CH (MAX_CH)
    ) u_analyzer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_accept && s_tlast),
        .cfg      (cfg_reg),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .res_take (res_take),
        .status   (status),
        .result   (result)
    );

    assign s_tready = status.idle;

    // output register, refilled as soon as the previous transaction leaves
    assign res_take      = status.done && (!m_tvalid_reg || m_tready);
    assign m_tvalid_next = res_take || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        if (res_take) begin
            m_tdata_reg <= {{M_PAD_W{1'b0}}, result.in_count, result.out_count,
                            result.output_skip_mask, result.input_skip_mask,
                            result.output_zero_mask};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- hw/rtl/mmcr_store.sv -----
// coefficient class store, one write port and one registered read port
`timescale 1ns / 1ps

module mmcr_store
    import mmcr_pkg::*;
#(
    parameter int MAX_CH = 32
) (
    input  logic                              aclk,
    input  logic                              wr_en,
    input  logic [store_addr_w(MAX_CH)-1:0]   wr_addr,
    input  logic [CLS_W-1:0]                  wr_data,
    input  logic                              rd_en,
    input  logic [store_addr_w(MAX_CH)-1:0]   rd_addr,
    output logic [CLS_W-1:0]                  rd_data
);

    localparam int DEPTH = MAX_CH * MAX_CH;

    logic [CLS_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/mmcr_analyzer.sv -----
// matrix walk and channel mask sequencer
`timescale 1ns / 1ps

module mmcr_analyzer
    import mmcr_pkg::*;
#(
    parameter int MAX_CH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  mmcr_cfg_t                         cfg,
    output logic                              rd_en,
    output logic [store_addr_w(MAX_CH)-1:0]   rd_addr,
    input  logic [CLS_W-1:0]                  rd_data,
    input  logic                              res_take,
    output mmcr_status_t                      status,
    output mmcr_result_t                      result
);

    localparam int AW    = store_addr_w(MAX_CH);
    localparam int CLAMP = (MAX_CH < MASK_W) ? MAX_CH : MASK_W;
    localparam logic [CNT_W-1:0] CLAMP_C = CNT_W'(CLAMP);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PH1,
        ST_CHK1,
        ST_PH2,
        ST_CHK2,
        ST_PH3,
        ST_CHK3,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]  r_reg, r_next, c_reg, c_next, j_reg, j_next;
    logic              rv_reg, rv_next;
    logic [IDX_W-1:0]  rr_reg, rc_reg;
    logic [MASK_W-1:0] row_off_reg, row_off_next;
    logic [MASK_W-1:0] col_off_reg, col_off_next;
    logic [MASK_W-1:0] diag_one_reg, diag_one_next;
    logic [MASK_W-1:0] diag_nz_reg, diag_nz_next;
    logic [MASK_W-1:0] zero_reg, zero_next;
    logic [MASK_W-1:0] in_skip_reg, in_skip_next;
    logic [MASK_W-1:0] out_skip_reg, out_skip_next;
    logic [CNT_W-1:0]  out_left_reg, out_left_next;
    logic [CNT_W-1:0]  in_left_reg, in_left_next;

    logic [CNT_W-1:0]  nin, nout, sq;
    logic [CNT_W-1:0]  jx;
    logic              c_end, r_end;
    logic              ident, ph1_ok, ph2_ok;

    // channel counts limited to the store and mask size
    assign nin  = (cfg.in_channels  > CLAMP_C) ? CLAMP_C : cfg.in_channels;
    assign nout = (cfg.out_channels > CLAMP_C) ? CLAMP_C : cfg.out_channels;
    assign sq   = (nin < nout) ? nin : nout;

    // walk position
    assign c_end = ({1'b0, c_reg} + CNT_W'(1)) == nin;
    assign r_end = ({1'b0, r_reg} + CNT_W'(1)) == nout;
    assign jx    = {1'b0, j_reg};

    // store read request
    assign rd_en   = (state_reg == ST_SCAN);
    assign rd_addr = AW'(AW'(r_reg) * AW'(MAX_CH)) + AW'(c_reg);

    // per-channel tests from the row and column summaries
    assign ident  = diag_one_reg[j_reg] && !row_off_reg[j_reg] && !col_off_reg[j_reg];
    assign ph1_ok = !row_off_reg[j_reg] && !diag_nz_reg[j_reg]
                    && ((jx >= nin) || !col_off_reg[j_reg]);
    assign ph2_ok = (jx < sq) ? ident : !col_off_reg[j_reg];

    always_comb begin
        state_next    = state_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        j_next        = j_reg;
        row_off_next  = row_off_reg;
        col_off_next  = col_off_reg;
        diag_one_next = diag_one_reg;
        diag_nz_next  = diag_nz_reg;
        zero_next     = zero_reg;
        in_skip_next  = in_skip_reg;
        out_skip_next = out_skip_reg;
        out_left_next = out_left_reg;
        in_left_next  = in_left_reg;

        // read pipeline follows the walk
        rv_next = (state_reg == ST_SCAN);

        // fold returned class into the row and column summaries
        if (rv_reg) begin
            if (rr_reg == rc_reg) begin
                diag_one_next[rr_reg] = (rd_data == CLS_ONE);
                diag_nz_next[rr_reg]  = (rd_data != CLS_ZERO);
            end else begin
                row_off_next[rr_reg] = row_off_reg[rr_reg] | (rd_data != CLS_ZERO);
                col_off_next[rc_reg] = col_off_reg[rc_reg] | (rd_data != CLS_ZERO);
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    r_next        = '0;
                    c_next        = '0;
                    j_next        = '0;
                    row_off_next  = '0;
                    col_off_next  = '0;
                    diag_one_next = '0;
                    diag_nz_next  = '0;
                    zero_next     = '0;
                    in_skip_next  = '0;
                    out_skip_next = '0;
                    out_left_next = cfg.start_out_count;
                    in_left_next  = cfg.start_in_count;
                    if (nin != '0 && nout != '0) begin
                        state_next = ST_SCAN;
                    end else if (nout != '0) begin
                        state_next = ST_PH1;
                    end else begin
                        state_next = ST_CHK1;
                    end
                end
            end
            ST_SCAN: begin
                if (c_end) begin
                    c_next = '0;
                    r_next = r_reg + IDX_W'(1);
                    if (r_end) begin
                        state_next = ST_DRAIN;
                    end
                end else begin
                    c_next = c_reg + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                state_next = ST_PH1;
            end
            // silent outputs
            ST_PH1: begin
                if (ph1_ok) begin
                    zero_next[j_reg] = 1'b1;
                    out_left_next    = dec_sat(out_left_reg);
                end
                j_next = j_reg + IDX_W'(1);
                if ((jx + CNT_W'(1)) == nout) begin
                    j_next     = '0;
                    state_next = ST_CHK1;
                end
            end
            ST_CHK1: begin
                if (out_left_reg == '0) begin
                    in_left_next = '0;
                    state_next   = ST_DONE;
                end else if (nin != '0) begin
                    state_next = ST_PH2;
                end else begin
                    state_next = ST_CHK2;
                end
            end
            // passthrough and unused inputs
            ST_PH2: begin
                if (ph2_ok) begin
                    in_skip_next[j_reg] = 1'b1;
                    in_left_next        = dec_sat(in_left_reg);
                end
                j_next = j_reg + IDX_W'(1);
                if ((jx + CNT_W'(1)) == nin) begin
                    j_next     = '0;
                    state_next = ST_CHK2;
                end
            end
            ST_CHK2: begin
                if (in_left_reg == '0) begin
                    out_left_next = '0;
                    state_next    = ST_DONE;
                end else if (sq != '0) begin
                    state_next = ST_PH3;
                end else begin
                    state_next = ST_CHK3;
                end
            end
            // identity outputs
            ST_PH3: begin
                if (ident) begin
                    out_skip_next[j_reg] = 1'b1;
                    out_left_next        = dec_sat(out_left_reg);
                end
                j_next = j_reg + IDX_W'(1);
                if ((jx + CNT_W'(1)) == sq) begin
                    j_next     = '0;
                    state_next = ST_CHK3;
                end
            end
            ST_CHK3: begin
                if (out_left_reg == '0) begin
                    in_left_next = '0;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rv_reg       <= 1'b0;
            zero_reg     <= '0;
            in_skip_reg  <= '0;
            out_skip_reg <= '0;
            out_left_reg <= '0;
            in_left_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            rv_reg       <= rv_next;
            zero_reg     <= zero_next;
            in_skip_reg  <= in_skip_next;
            out_skip_reg <= out_skip_next;
            out_left_reg <= out_left_next;
            in_left_reg  <= in_left_next;
        end
        r_reg        <= r_next;
        c_reg        <= c_next;
        j_reg        <= j_next;
        rr_reg       <= r_reg;
        rc_reg       <= c_reg;
        row_off_reg  <= row_off_next;
        col_off_reg  <= col_off_next;
        diag_one_reg <= diag_one_next;
        diag_nz_reg  <= diag_nz_next;
    end

    assign status.idle = (state_reg == ST_IDLE);
    assign status.done = (state_reg == ST_DONE);

    assign result.output_zero_mask = zero_reg;
    assign result.input_skip_mask  = in_skip_reg;
    assign result.output_skip_mask = out_skip_reg;
    assign result.out_count        = out_left_reg;
    assign result.in_count         = in_left_reg;

endmodule

// ----- hw/rtl/mmcr_checker.sv -----
// port-level checks of the mixing-matrix channel reducer and their bind
`timescale 1ns / 1ps
`include "mix_matrix_channel_reducer_defines.svh"

module mmcr_checker
    import mmcr_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  s_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata
);

    // a stalled result holds
    `MMCR_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // a last entry starts the analysis and closes the input
    `MMCR_ASSERT_NEXT(a_busy_after_last, s_tvalid && s_tready && s_tlast, !s_tready, "input still open after last entry")

    // an exhausted output count clears the input count
    `MMCR_ASSERT_NOW(a_counts_cleared, m_tvalid && (m_tdata[OUT_CNT_LSB +: CNT_W] == '0), m_tdata[IN_CNT_LSB +: CNT_W] == '0, "in_count left set with out_count zero")

    // a silent output is never an identity output
    `MMCR_ASSERT_NOW(a_masks_disjoint, m_tvalid, (m_tdata[ZERO_LSB +: MASK_W] & m_tdata[OUT_SKIP_LSB +: MASK_W]) == '0, "output both silent and passthrough")

endmodule

bind mix_matrix_channel_reducer mmcr_checker u_mmcr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/sv/tb_mix_matrix_channel_reducer.sv -----
// testbench for the mixing-matrix channel reducer: random matrices checked against a predictor
`timescale 1ns / 1ps

module tb_mix_matrix_channel_reducer;
    import mmcr_pkg::*;

    localparam int CH           = 32;
    localparam int RANDOM_ITEMS = 1750;
    localparam int LIMIT_CYCLES = 6000000;
    localparam int DRAIN_CYCLES = 1200;
    localparam int SETTLE       = 8;

    typedef enum {PAT_SPARSE, PAT_IDENTITY, PAT_UNIFORM} pattern_t;
    typedef enum {FRAME_FULL, FRAME_EDIT, FRAME_NOISE} frame_kind_t;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [CLS_W-1:0] cls;
    } entry_t;

    // holds the predicted coefficient store, register copies and pending mask results
    class mask_scoreboard;
        logic [CLS_W-1:0] coef [CH][CH];
        bit               written [CH][CH];
        logic [CNT_W-1:0] in_channels;
        logic [CNT_W-1:0] out_channels;
        logic [CNT_W-1:0] start_in;
        logic [CNT_W-1:0] start_out;
        mmcr_result_t     expected_masks[$];
        int               errors;

        function new();
            in_channels  = CFG_RESET_VAL;
            out_channels = CFG_RESET_VAL;
            start_in     = CFG_RESET_VAL;
            start_out    = CFG_RESET_VAL;
            errors       = 0;
            foreach (written[r, c]) begin
                written[r][c] = 1'b0;
                coef[r][c]    = CLS_ZERO;
            end
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CNT_W-1:0] value);
            case (addr)
                REG_IN_CHANNELS:  in_channels  = value;
                REG_OUT_CHANNELS: out_channels = value;
                REG_START_IN:     start_in     = value;
                REG_START_OUT:    start_out    = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_masks.size();
        endfunction

        function int clamp_ch(logic [CNT_W-1:0] n);
            return (n > CH) ? CH : int'(n);
        endfunction

        function logic [CNT_W-1:0] count_down(logic [CNT_W-1:0] v);
            return (v == '0) ? v : v - CNT_W'(1);
        endfunction

        // three-pass analysis of the stored matrix
        function mmcr_result_t predict_masks();
            mmcr_result_t res;
            int nin, nout, sq, o, i, k;
            bit ok;
            nin  = clamp_ch(in_channels);
            nout = clamp_ch(out_channels);
            sq   = (nin < nout) ? nin : nout;
            res  = '0;
            res.out_count = start_out;
            res.in_count  = start_in;

            // silent outputs: row zero, and same-index column zero where it exists
            for (o = 0; o < nout; o++) begin
                ok = 1'b1;
                for (i = 0; i < nin; i++)
                    if (coef[o][i] != CLS_ZERO) ok = 1'b0;
                if (o < nin)
                    for (k = 0; k < nout; k++)
                        if (coef[k][o] != CLS_ZERO) ok = 1'b0;
                if (ok) begin
                    res.output_zero_mask[o] = 1'b1;
                    res.out_count = count_down(res.out_count);
                end
            end
            if (res.out_count == '0) begin
                res.in_count = '0;
                return res;
            end

            // passthrough inputs in the square part
            for (i = 0; i < sq; i++) begin
                ok = 1'b1;
                for (o = 0; o < nout; o++) begin
                    if (o == i) begin
                        if (coef[o][i] != CLS_ONE) ok = 1'b0;
                        for (k = 0; k < nin; k++)
                            if (k != i && coef[o][k] != CLS_ZERO) ok = 1'b0;
                    end else if (coef[o][i] != CLS_ZERO) begin
                        ok = 1'b0;
                    end
                end
                if (ok) begin
                    res.input_skip_mask[i] = 1'b1;
                    res.in_count = count_down(res.in_count);
                end
            end
            // unused inputs beyond the square part
            for (i = sq; i < nin; i++) begin
                ok = 1'b1;
                for (o = 0; o < nout; o++)
                    if (coef[o][i] != CLS_ZERO) ok = 1'b0;
                if (ok) begin
                    res.input_skip_mask[i] = 1'b1;
                    res.in_count = count_down(res.in_count);
                end
            end
            if (res.in_count == '0) begin
                res.out_count = '0;
                return res;
            end

            // outputs copied from the same-index input
            for (o = 0; o < sq; o++) begin
                ok = 1'b1;
                for (i = 0; i < nin; i++)
                    if ((o != i && coef[o][i] != CLS_ZERO) || (o == i && coef[o][i] != CLS_ONE))
                        ok = 1'b0;
                for (k = 0; k < nout; k++)
                    if (k != o && coef[k][o] != CLS_ZERO) ok = 1'b0;
                if (ok) begin
                    res.output_skip_mask[o] = 1'b1;
                    res.out_count = count_down(res.out_count);
                end
            end
            if (res.out_count == '0) res.in_count = '0;
            return res;
        endfunction

        // accepted input transaction
        function void note_entry(entry_t e, bit last);
            coef[e.row][e.col]    = (e.cls == CLS_RSVD) ? CLS_OTHER : e.cls;
            written[e.row][e.col] = 1'b1;
            if (last) expected_masks.push_back(predict_masks());
        endfunction

        function void flag(string what, logic [31:0] exp_v, logic [31:0] act_v);
            errors++;
            if (errors <= 10)
                $display("mismatch on %0s: expected %h, got %h", what, exp_v, act_v);
        endfunction

        // accepted output transaction
        function void check_masks(logic [M_TDATA_W-1:0] data);
            mmcr_result_t exp_r;
            if (expected_masks.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", data);
                return;
            end
            exp_r = expected_masks.pop_front();
            if (data[ZERO_LSB +: MASK_W] != exp_r.output_zero_mask)
                flag("output_zero_mask", exp_r.output_zero_mask, data[ZERO_LSB +: MASK_W]);
            if (data[IN_SKIP_LSB +: MASK_W] != exp_r.input_skip_mask)
                flag("input_skip_mask", exp_r.input_skip_mask, data[IN_SKIP_LSB +: MASK_W]);
            if (data[OUT_SKIP_LSB +: MASK_W] != exp_r.output_skip_mask)
                flag("output_skip_mask", exp_r.output_skip_mask, data[OUT_SKIP_LSB +: MASK_W]);
            if (data[OUT_CNT_LSB +: CNT_W] != exp_r.out_count)
                flag("out_count", 32'(exp_r.out_count), 32'(data[OUT_CNT_LSB +: CNT_W]));
            if (data[IN_CNT_LSB +: CNT_W] != exp_r.in_count)
                flag("in_count", 32'(exp_r.in_count), 32'(data[IN_CNT_LSB +: CNT_W]));
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CNT_W-1:0]      cfg_wdata = '0;

    mask_scoreboard sb = new();

    int          entries_sent = 0;
    int unsigned cycles       = 0;
    bit          send_quiet   = 1'b0;
    bit          recv_quiet   = 1'b0;
    int          rect_rows    = 2;
    int          rect_cols    = 2;
    pattern_t    pattern      = PAT_IDENTITY;
    logic [31:0] dead_rows    = '0;
    logic [31:0] dead_cols    = '0;
    entry_t      frame_q[$];

    mix_matrix_channel_reducer #(.MAX_CH(CH)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("tb_mix_matrix_channel_reducer failed");
            $finish;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_masks(m_tdata);
    end

    // result side back-pressure, one stall draw per transaction
    initial begin
        int n;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            n = recv_quiet ? 0 : $urandom_range(0, 15);
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    function automatic entry_t make_entry(int r, int c, logic [CLS_W-1:0] cls);
        entry_t e;
        e.row = IDX_W'(r);
        e.col = IDX_W'(c);
        e.cls = cls;
        return e;
    endfunction

    function automatic logic [CLS_W-1:0] pattern_class(int r, int c);
        logic [CLS_W-1:0] cls;
        if (dead_rows[r] || dead_cols[c]) begin
            cls = CLS_ZERO;
        end else begin
            case (pattern)
                PAT_IDENTITY: cls = (r == c) ? CLS_ONE : CLS_ZERO;
                PAT_SPARSE:   cls = ($urandom_range(0, 5) == 0) ?
                                    CLS_W'($urandom_range(1, 3)) : CLS_ZERO;
                default:      cls = CLS_W'($urandom_range(0, 3));
            endcase
        end
        // rare disturbance of the pattern
        if ($urandom_range(0, 39) == 0) cls = CLS_W'($urandom_range(0, 3));
        return cls;
    endfunction

    // one entry anywhere in the store with a random class
    function automatic entry_t stray_entry();
        return make_entry($urandom_range(0, CH - 1), $urandom_range(0, CH - 1),
                          CLS_W'($urandom_range(0, 3)));
    endfunction

    function automatic void build_frame(frame_kind_t kind);
        int r, c, j;
        entry_t e;
        frame_q.delete();
        case (kind)
            FRAME_FULL: begin
                for (r = 0; r < rect_rows; r++)
                    for (c = 0; c < rect_cols; c++)
                        frame_q.push_back(make_entry(r, c, pattern_class(r, c)));
            end
            FRAME_EDIT: begin
                // fill any entry the analysis would read that was never written
                for (r = 0; r < rect_rows; r++)
                    for (c = 0; c < rect_cols; c++)
                        if (!sb.written[r][c])
                            frame_q.push_back(make_entry(r, c, pattern_class(r, c)));
                if (rect_rows > 0 && rect_cols > 0) begin
                    repeat ($urandom_range(1, 6)) begin
                        r = $urandom_range(0, rect_rows - 1);
                        c = $urandom_range(0, rect_cols - 1);
                        frame_q.push_back(make_entry(r, c, $urandom_range(0, 1) ?
                            pattern_class(r, c) : CLS_W'($urandom_range(0, 3))));
                    end
                end
                repeat ($urandom_range(0, 2)) frame_q.push_back(stray_entry());
            end
            default: begin
                repeat ($urandom_range(1, 5)) frame_q.push_back(stray_entry());
            end
        endcase
        if (frame_q.size() == 0) frame_q.push_back(stray_entry());
        // shuffle half of the frames
        if ($urandom_range(0, 1)) begin
            for (r = frame_q.size() - 1; r > 0; r--) begin
                j = $urandom_range(0, r);
                e = frame_q[r];
                frame_q[r] = frame_q[j];
                frame_q[j] = e;
            end
        end
    endfunction

    // drive one entry and wait for its transaction
    task automatic send_entry(entry_t e, bit last);
        logic [S_TDATA_W-1:0] word;
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        word = '0;
        word[ROW_LSB +: IDX_W] = e.row;
        word[COL_LSB +: IDX_W] = e.col;
        word[CLS_LSB +: CLS_W] = e.cls;
        s_tdata  <= word;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_entry(e, last);
        entries_sent++;
    endtask

    task automatic send_frame(frame_kind_t kind);
        int idx;
        build_frame(kind);
        for (idx = 0; idx < frame_q.size(); idx++)
            send_entry(frame_q[idx], kind != FRAME_NOISE && idx == frame_q.size() - 1);
    endtask

    // let every pending result drain before touching registers
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_config(logic [CNT_W-1:0] nin, logic [CNT_W-1:0] nout,
                                logic [CNT_W-1:0] sin, logic [CNT_W-1:0] sout);
        logic [CFG_ADDR_W-1:0] addrs [4];
        logic [CNT_W-1:0]      vals [4];
        int first, n, slot;
        addrs = '{REG_IN_CHANNELS, REG_OUT_CHANNELS, REG_START_IN, REG_START_OUT};
        vals  = '{nin, nout, sin, sout};
        first = $urandom_range(0, 3);
        for (n = 0; n < 4; n++) begin
            slot = (first + n) % 4;
            cfg_wr_en <= 1'b1;
            cfg_addr  <= addrs[slot];
            cfg_wdata <= vals[slot];
            @(posedge aclk);
            sb.set_reg(addrs[slot], vals[slot]);
        end
        cfg_wr_en <= 1'b0;
        rect_rows = sb.clamp_ch(nout);
        rect_cols = sb.clamp_ch(nin);
    endtask

    function automatic logic [CNT_W-1:0] pick_start();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CNT_W'($urandom_range(33, 63));
            2, 3:    return CNT_W'($urandom_range(1, 2));
            default: return CNT_W'($urandom_range(0, 32));
        endcase
    endfunction

    // stimulus
    initial begin
        int target, shape, n;
        bit big_done, big;
        logic [CNT_W-1:0] nin, nout;
        frame_kind_t kind;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, 2x2 identity
        send_entry(make_entry(0, 0, CLS_ONE), 1'b0);
        send_entry(make_entry(0, 1, CLS_ZERO), 1'b0);
        send_entry(make_entry(1, 0, CLS_ZERO), 1'b0);
        send_entry(make_entry(1, 1, CLS_ONE), 1'b1);
        // reserved class acts as other
        send_entry(make_entry(1, 1, CLS_RSVD), 1'b1);
        // all-zero matrix, early stop after silent outputs
        send_entry(make_entry(0, 0, CLS_ZERO), 1'b0);
        send_entry(make_entry(1, 1, CLS_ZERO), 1'b1);
        // top corners of the store, outside the used matrix
        send_entry(make_entry(31, 31, CLS_RSVD), 1'b0);
        send_entry(make_entry(31, 0, CLS_OTHER), 1'b0);
        send_entry(make_entry(0, 31, CLS_ONE), 1'b0);
        send_entry(make_entry(0, 1, CLS_OTHER), 1'b1);
        // swapped channels
        send_entry(make_entry(1, 0, CLS_ONE), 1'b0);
        send_entry(make_entry(0, 1, CLS_ONE), 1'b0);
        send_entry(make_entry(1, 1, CLS_ZERO), 1'b0);
        send_entry(make_entry(0, 0, CLS_ZERO), 1'b1);
        // zero starting counts end at the first check
        wait_idle();
        write_config(6'd2, 6'd2, 6'd0, 6'd0);
        send_entry(make_entry(0, 1, CLS_ZERO), 1'b1);
        // largest register values
        wait_idle();
        write_config(6'd2, 6'd2, 6'd63, 6'd63);
        send_entry(make_entry(1, 0, CLS_ZERO), 1'b0);
        send_entry(make_entry(0, 0, CLS_ONE), 1'b1);

        // random phases
        target   = entries_sent + RANDOM_ITEMS;
        big_done = 1'b0;
        while (entries_sent < target) begin
            wait_idle();
            big = 1'b0;
            if (!big_done && entries_sent > target - 700) begin
                // full-size matrix, once
                big      = 1'b1;
                big_done = 1'b1;
                write_config(6'd32, 6'd32, 6'd32, 6'd32);
            end else begin
                shape = $urandom_range(0, 9);
                case (shape)
                    6: begin
                        nin  = 6'd32;
                        nout = CNT_W'($urandom_range(1, 3));
                    end
                    7: begin
                        nin  = CNT_W'($urandom_range(1, 3));
                        nout = 6'd32;
                    end
                    8: begin
                        nin  = $urandom_range(0, 1) ? '0 : CNT_W'($urandom_range(33, 63));
                        nout = CNT_W'($urandom_range(1, 3));
                    end
                    9: begin
                        nin  = CNT_W'($urandom_range(1, 3));
                        nout = $urandom_range(0, 1) ? '0 : CNT_W'($urandom_range(33, 63));
                    end
                    default: begin
                        nin  = CNT_W'($urandom_range(1, 6));
                        nout = CNT_W'($urandom_range(1, 6));
                    end
                endcase
                write_config(nin, nout, pick_start(), pick_start());
            end
            send_quiet = ($urandom_range(0, 3) == 0);
            recv_quiet = ($urandom_range(0, 3) == 0);

            n = big ? $urandom_range(2, 3) : $urandom_range(2, 6);
            repeat (n) begin
                pattern   = pattern_t'($urandom_range(0, 2));
                dead_rows = ($urandom_range(0, 2) == 0) ? '0 : ($urandom & $urandom);
                dead_cols = dead_rows | ($urandom & $urandom & $urandom);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: kind = FRAME_FULL;
                    5, 6, 7:       kind = FRAME_EDIT;
                    default:       kind = FRAME_NOISE;
                endcase
                if (kind == FRAME_FULL && rect_rows * rect_cols > 64) kind = FRAME_EDIT;
                send_frame(kind);
            end
        end

        // drain and finish
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_mix_matrix_channel_reducer passed");
        end else begin
            $display("tb_mix_matrix_channel_reducer failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/mmcr_pkg.sv
hw/rtl/mmcr_store.sv
hw/rtl/mmcr_analyzer.sv
hw/rtl/mix_matrix_channel_reducer.sv
hw/rtl/mmcr_checker.sv
tb/sv/tb_mix_matrix_channel_reducer.sv
